### rtl/string_isomorphism_checker_unit_defines.svh
// Assertion macros for the string isomorphism checker.
`ifndef STRING_ISOMORPHISM_CHECKER_UNIT_DEFINES_SVH
`define STRING_ISOMORPHISM_CHECKER_UNIT_DEFINES_SVH
`ifndef SYNTH
`define SIC_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sic: same-cycle check failed");
`define SIC_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sic: next-cycle check failed");
`else
`define SIC_ASSERT_NOW(label, clk, rst, ante, cons)
`define SIC_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

### rtl/sic_pkg.sv
package sic_pkg;

  localparam int CHAR_W            = 7;
  localparam int ALPHABET_SIZE_DEF = 128;

  typedef struct packed {
    logic [CHAR_W-1:0] s_char;
    logic [CHAR_W-1:0] t_char;
    logic              s_end;
    logic              t_end;
  } sic_item_t;

endpackage

### rtl/sic_if.sv
interface sic_req_if import sic_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] s_char;
  logic [CHAR_W-1:0] t_char;
  logic              s_end;
  logic              t_end;

  modport source (output valid, s_char, t_char, s_end, t_end, input ready);
  modport sink (input valid, s_char, t_char, s_end, t_end, output ready);
endinterface

interface sic_rsp_if;
  logic valid;
  logic ready;
  logic is_isomorphic;

  modport source (output valid, is_isomorphic, input ready);
  modport sink (input valid, is_isomorphic, output ready);
endinterface

### rtl/string_isomorphism_checker_unit.sv
// String isomorphism checker. Each request carries one character of each
// string and their end marks; a request with either end mark set yields one
// verdict on rsp (1 only when both strings end together and a one-to-one
// character mapping exists), after which the maps are cleared for the next
// pair of strings. One request is taken every cycle unless an end request
// waits in s1; a request is registered in s1, its verdict then in out_bit.
// The forward map sits in a memory with a registered read, looked up the
// cycle a request is taken and checked the cycle after, with the previous
// cycle's write forwarded. Occupancy bits are flip-flops cleared all at once,
// so no clearing pass is needed after reset or between strings. A request
// that ends a string waits only while an earlier verdict is still unread.
`include "string_isomorphism_checker_unit_defines.svh"

module string_isomorphism_checker_unit import sic_pkg::*; #(
  parameter int ALPHABET_SIZE = ALPHABET_SIZE_DEF
) (
  input  logic      clk,
  input  logic      rst,
  sic_req_if.sink   req,
  sic_rsp_if.source rsp
);

  localparam int IDX_W = $clog2(ALPHABET_SIZE);
  localparam int EXT_W = ((IDX_W > CHAR_W) ? IDX_W : CHAR_W) + 1;

  sic_item_t         s1;
  logic              s1_valid;
  logic              s1_end;
  logic              s1_adv;
  logic              commit;
  logic              accept;
  logic              out_valid;
  logic              out_bit;
  logic              verdict;
  logic [CHAR_W-1:0] rd_char;
  logic [EXT_W-1:0]  rd_ext;
  logic [IDX_W-1:0]  rd_addr;
  logic [CHAR_W-1:0] rd_data;
  logic              wr_en;
  logic [IDX_W-1:0]  wr_addr;
  logic [CHAR_W-1:0] wr_data;

  always_comb begin
    s1_end    = s1.s_end | s1.t_end;
    s1_adv    = !s1_end || !out_valid || rsp.ready;
    commit    = s1_valid && s1_adv;
    req.ready = !s1_valid || s1_adv;
    accept    = req.valid && req.ready;
    rd_char   = accept ? req.s_char : s1.s_char;
    rd_ext    = EXT_W'(rd_char);
    rd_addr   = rd_ext[IDX_W-1:0];
  end

  assign rsp.valid         = out_valid;
  assign rsp.is_isomorphic = out_bit;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      s1_valid <= accept || (s1_valid && !commit);
      if (commit && s1_end) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1 <= '{s_char: req.s_char, t_char: req.t_char, s_end: req.s_end, t_end: req.t_end};
    end
    if (commit && s1_end) begin
      out_bit <= verdict;
    end
  end

  sic_map_mem #(
    .ALPHABET_SIZE(ALPHABET_SIZE)
  ) u_map_mem (
    .clk    (clk),
    .rd_addr(rd_addr),
    .rd_data(rd_data),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data)
  );

  sic_check #(
    .ALPHABET_SIZE(ALPHABET_SIZE)
  ) u_check (
    .clk    (clk),
    .rst    (rst),
    .commit (commit),
    .item   (s1),
    .rd_data(rd_data),
    .verdict(verdict),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data)
  );

  `SIC_ASSERT_NOW(a_no_verdict_overwrite, clk, rst, out_valid && !rsp.ready, !(commit && s1_end))
  `SIC_ASSERT_NEXT(a_accept_fills_stage, clk, rst, accept, s1_valid)
  `SIC_ASSERT_NEXT(a_end_gives_verdict, clk, rst, commit && s1_end, out_valid)

endmodule

### rtl/sic_map_mem.sv
module sic_map_mem import sic_pkg::*; #(
  parameter int ALPHABET_SIZE = ALPHABET_SIZE_DEF
) (
  input  logic                             clk,
  input  logic [$clog2(ALPHABET_SIZE)-1:0] rd_addr,
  output logic [CHAR_W-1:0]                rd_data,
  input  logic                             wr_en,
  input  logic [$clog2(ALPHABET_SIZE)-1:0] wr_addr,
  input  logic [CHAR_W-1:0]                wr_data
);

  logic [CHAR_W-1:0] mem [ALPHABET_SIZE];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

### rtl/sic_check.sv
`include "string_isomorphism_checker_unit_defines.svh"

module sic_check import sic_pkg::*; #(
  parameter int ALPHABET_SIZE = ALPHABET_SIZE_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             commit,
  input  sic_item_t                        item,
  input  logic [CHAR_W-1:0]                rd_data,
  output logic                             verdict,
  output logic                             wr_en,
  output logic [$clog2(ALPHABET_SIZE)-1:0] wr_addr,
  output logic [CHAR_W-1:0]                wr_data
);

  localparam int IDX_W = $clog2(ALPHABET_SIZE);
  localparam int EXT_W = ((IDX_W > CHAR_W) ? IDX_W : CHAR_W) + 1;

  // Reverse direction only needs occupancy: a taken partner with a fresh
  // forward entry is always a conflict.
  logic [ALPHABET_SIZE-1:0] fwd_valid;
  logic [ALPHABET_SIZE-1:0] rev_valid;
  logic                     mismatch_seen;
  logic                     fwd_hit;
  logic [IDX_W-1:0]         fwd_addr;
  logic [CHAR_W-1:0]        fwd_data;

  logic [EXT_W-1:0]  a_ext;
  logic [EXT_W-1:0]  b_ext;
  logic [IDX_W-1:0]  a_idx;
  logic [IDX_W-1:0]  b_idx;
  logic              out_range;
  logic [CHAR_W-1:0] partner;
  logic              seq_end;
  logic              pair_bad;
  logic              pair_new;
  logic              mismatch_next;

  always_comb begin
    a_ext     = EXT_W'(item.s_char);
    b_ext     = EXT_W'(item.t_char);
    a_idx     = a_ext[IDX_W-1:0];
    b_idx     = b_ext[IDX_W-1:0];
    out_range = (a_ext >= EXT_W'(ALPHABET_SIZE)) || (b_ext >= EXT_W'(ALPHABET_SIZE));
    // write in the previous cycle is not yet visible in the read data
    partner   = (fwd_hit && (fwd_addr == a_idx)) ? fwd_data : rd_data;
    seq_end   = item.s_end | item.t_end;
    pair_bad  = 1'b0;
    pair_new  = 1'b0;
    if (!mismatch_seen) begin
      priority if (out_range) begin
        pair_bad = 1'b1;
      end else if (fwd_valid[a_idx]) begin
        pair_bad = (partner != item.t_char);
      end else if (rev_valid[b_idx]) begin
        pair_bad = 1'b1;
      end else begin
        pair_new = 1'b1;
      end
    end
    mismatch_next = mismatch_seen | pair_bad;
    verdict       = (item.s_end == item.t_end) && !mismatch_next;
    wr_en         = commit && pair_new && !seq_end;
    wr_addr       = a_idx;
    wr_data       = item.t_char;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_valid     <= '0;
      rev_valid     <= '0;
      mismatch_seen <= 1'b0;
      fwd_hit       <= 1'b0;
    end else begin
      fwd_hit <= wr_en;
      if (commit) begin
        if (seq_end) begin
          fwd_valid     <= '0;
          rev_valid     <= '0;
          mismatch_seen <= 1'b0;
        end else begin
          mismatch_seen <= mismatch_next;
          if (pair_new) begin
            fwd_valid[a_idx] <= 1'b1;
            rev_valid[b_idx] <= 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    fwd_addr <= wr_addr;
    fwd_data <= wr_data;
  end

  `SIC_ASSERT_NEXT(a_clear_after_end, clk, rst, commit && seq_end, !mismatch_seen && fwd_valid == '0)
  `SIC_ASSERT_NOW(a_true_needs_both_ends, clk, rst, commit && seq_end && verdict, item.s_end && item.t_end)
  `SIC_ASSERT_NOW(a_write_fresh_only, clk, rst, wr_en, !fwd_valid[a_idx] && !rev_valid[b_idx])

endmodule
